[hdl/azm_pkg.sv]
// Shared types and constants of the alarm zone monitor.
// No dependencies; imported by the top level alarm_zone_monitor.
`default_nettype none
package azm_pkg;

  localparam int NUM_ZONES        = 9;
  localparam int NUM_ANALOG_ZONES = 5;
  localparam int ADC_BITS         = 12;

  localparam int ZONE_W     = 4;
  localparam int ZONE_AW    = $clog2(NUM_ZONES);
  localparam int OPCODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int CD_W       = 12;
  localparam int PROD_W     = 16;
  localparam int BOUND_W    = PROD_W + 2;

  localparam int COEF_W       = 8;
  localparam int BOUND_TBL_W  = 8 * NUM_ANALOG_ZONES;
  localparam int MODE_TBL_W   = 3 * NUM_ZONES;
  localparam int DELAY_LO_W   = 40;
  localparam int DELAY_HI_W   = 32;
  localparam int DELAY_TBL_W  = DELAY_LO_W + DELAY_HI_W;

  localparam logic [COEF_W-1:0]      COEF_RST     = 8'd100;
  localparam logic [BOUND_TBL_W-1:0] LOW_TBL_RST  = 40'd12935367427;
  localparam logic [BOUND_TBL_W-1:0] HIGH_TBL_RST = 40'd30182524679;
  localparam logic [MODE_TBL_W-1:0]  MODE_TBL_RST = '0;
  localparam logic [DELAY_LO_W-1:0]  DELAY_LO_RST = 40'd6;
  localparam logic [DELAY_HI_W-1:0]  DELAY_HI_RST = '0;

  localparam logic [CD_W-1:0] CD_IDLE = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY_COEF = 3'd0,
    CFG_LOW_TBL     = 3'd1,
    CFG_HIGH_TBL    = 3'd2,
    CFG_MODE_TBL    = 3'd3,
    CFG_DELAY_LO    = 3'd4,
    CFG_DELAY_HI    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic            active;
    logic            latched;
    logic [CD_W-1:0] countdown;
  } zone_entry_t;

  localparam int ENTRY_W = $bits(zone_entry_t);

  localparam zone_entry_t ENTRY_RST = '{active: 1'b0, latched: 1'b0, countdown: CD_IDLE};

  typedef struct packed {
    logic abnormal;
    logic out_on;
    logic out_off;
    logic arm_req;
    logic disarm_req;
    logic fire;
    logic stop;
  } result_flags_t;

endpackage
`default_nettype wire

[hdl/alarm_zone_monitor.sv]
// Top level of the alarm zone monitor: configuration registers, control FSM and zone logic.
// Depends on azm_pkg and on azm_ram, which holds the per-zone state.
//
//  Channel | Ports                                          | Direction
//  in      | in_valid/in_ready, opcode, zone, adc, pin, arm | request in
//  out     | out_valid/out_ready, seven flags, last zone    | request out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | write in
//
// A scan passes through the RAM read, the bound multiply and the update step before its result
// is written to the output register; only then is a new request accepted.
// A tick or a clear walks all zone entries through the RAM, one per cycle, and then writes
// its result to the output register.
// Other requests, and scans of an out-of-range zone, go straight to the output register.
// Reset clears per-entry valid flags at once, so no clearing pass is needed.
// A result held by the output register does not block acceptance of the next request,
// but that request waits for the output register to free up before it finishes.
`default_nettype none
module alarm_zone_monitor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [azm_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [azm_pkg::ZONE_W-1:0]       in_zone_index,
  input  wire logic [azm_pkg::ADC_BITS-1:0]     in_adc_sample,
  input  wire logic                             in_pin_level,
  input  wire logic                             in_guard_armed,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_zone_abnormal,
  output logic                                  out_output_on,
  output logic                                  out_output_off,
  output logic                                  out_arm_request,
  output logic                                  out_disarm_request,
  output logic                                  out_alarm_fire,
  output logic                                  out_scan_stop,
  output logic [azm_pkg::ZONE_W-1:0]            out_last_alarm_zone,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [azm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [azm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import azm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_SWEEP,
    S_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  opcode_t                op_r, op_nxt;
  logic [ZONE_W-1:0]      zone_r, zone_nxt;
  logic [ADC_BITS-1:0]    adc_r, adc_nxt;
  logic                   pin_r, pin_nxt;
  logic                   armed_r, armed_nxt;
  logic [ZONE_AW-1:0]     idx_r, idx_nxt;
  zone_entry_t            entry_r, entry_nxt;
  logic [PROD_W-1:0]      prod_lo_r, prod_lo_nxt;
  logic [PROD_W-1:0]      prod_hi_r, prod_hi_nxt;
  logic [ZONE_W-1:0]      recent_r, recent_nxt;
  result_flags_t          res_r, res_nxt;
  logic [NUM_ZONES-1:0]   vld_r, vld_nxt;
  logic [ZONE_AW-1:0]     rd_addr_r;

  logic                   out_valid_r, out_valid_nxt;
  result_flags_t          out_flags_r, out_flags_nxt;
  logic [ZONE_W-1:0]      out_zone_r, out_zone_nxt;

  logic [COEF_W-1:0]      coef_r;
  logic [BOUND_TBL_W-1:0] low_tbl_r;
  logic [BOUND_TBL_W-1:0] high_tbl_r;
  logic [MODE_TBL_W-1:0]  mode_tbl_r;
  logic [DELAY_LO_W-1:0]  delay_lo_r;
  logic [DELAY_HI_W-1:0]  delay_hi_r;

  logic                   ram_we;
  logic [ZONE_AW-1:0]     ram_waddr;
  logic [ZONE_AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  zone_entry_t            ram_entry;

  azm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ZONES)
  ) u_zone_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_entry = vld_r[rd_addr_r] ? zone_entry_t'(ram_rdata) : ENTRY_RST;

  function automatic logic [7:0] bound_setting(input logic [BOUND_TBL_W-1:0] tbl,
                                               input logic [ZONE_W-1:0] zone);
    logic [7:0] s;
    s = '0;
    for (int k = 0; k < NUM_ANALOG_ZONES; k++) begin
      if (zone == ZONE_W'(k)) begin
        s = tbl[8*k +: 8];
      end
    end
    return s;
  endfunction

  function automatic logic [2:0] zone_mode(input logic [MODE_TBL_W-1:0] tbl,
                                           input logic [ZONE_W-1:0] zone);
    logic [2:0] m;
    m = '0;
    for (int k = 0; k < NUM_ZONES; k++) begin
      if (zone == ZONE_W'(k)) begin
        m = tbl[3*k +: 3];
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] zone_delay(input logic [DELAY_TBL_W-1:0] tbl,
                                            input logic [ZONE_W-1:0] zone);
    logic [7:0] d;
    d = '0;
    for (int k = 0; k < NUM_ZONES; k++) begin
      if (zone == ZONE_W'(k)) begin
        d = tbl[8*k +: 8];
      end
    end
    return d;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_zone_abnormal   = out_flags_r.abnormal;
  assign out_output_on       = out_flags_r.out_on;
  assign out_output_off      = out_flags_r.out_off;
  assign out_arm_request     = out_flags_r.arm_req;
  assign out_disarm_request  = out_flags_r.disarm_req;
  assign out_alarm_fire      = out_flags_r.fire;
  assign out_scan_stop       = out_flags_r.stop;
  assign out_last_alarm_zone = out_zone_r;

  logic [2:0]          mode;
  logic [BOUND_W-1:0]  bound_lo;
  logic [BOUND_W-1:0]  bound_hi;
  logic [BOUND_W-1:0]  adc_ext;
  logic [7:0]          delay;
  logic                in_win;
  logic                abn;
  logic                checked;
  zone_entry_t         upd;
  zone_entry_t         swp;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    zone_nxt      = zone_r;
    adc_nxt       = adc_r;
    pin_nxt       = pin_r;
    armed_nxt     = armed_r;
    idx_nxt       = idx_r;
    entry_nxt     = entry_r;
    prod_lo_nxt   = prod_lo_r;
    prod_hi_nxt   = prod_hi_r;
    recent_nxt    = recent_r;
    res_nxt       = res_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_flags_nxt = out_flags_r;
    out_zone_nxt  = out_zone_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ENTRY_RST;
    ram_raddr     = idx_r;

    mode     = zone_mode(mode_tbl_r, zone_r);
    delay    = zone_delay({delay_hi_r, delay_lo_r}, zone_r);
    bound_lo = BOUND_W'({prod_lo_r, 1'b0}) + BOUND_W'(prod_lo_r);
    bound_hi = BOUND_W'({prod_hi_r, 1'b0}) + BOUND_W'(prod_hi_r);
    adc_ext  = BOUND_W'(adc_r);
    in_win   = (bound_hi > adc_ext) && (bound_lo < adc_ext);
    abn      = (zone_r < ZONE_W'(NUM_ANALOG_ZONES)) ? (in_win == mode[2]) : (pin_r == mode[2]);
    checked  = 1'b1;
    upd      = entry_r;
    swp      = ram_entry;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = opcode_t'(in_opcode);
          zone_nxt  = in_zone_index;
          adc_nxt   = in_adc_sample;
          pin_nxt   = in_pin_level;
          armed_nxt = in_guard_armed;
          res_nxt   = '0;
          idx_nxt   = '0;
          ram_raddr = '0;
          if (opcode_t'(in_opcode) == OP_SCAN && in_zone_index < ZONE_W'(NUM_ZONES)) begin
            ram_raddr = in_zone_index[ZONE_AW-1:0];
            state_nxt = S_LOAD;
          end else if (opcode_t'(in_opcode) == OP_TICK) begin
            state_nxt = S_SWEEP;
          end else if (opcode_t'(in_opcode) == OP_CLEAR) begin
            recent_nxt = '0;
            state_nxt  = S_SWEEP;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_LOAD: begin
        entry_nxt   = ram_entry;
        prod_lo_nxt = PROD_W'(bound_setting(low_tbl_r, zone_r)) * PROD_W'(coef_r);
        prod_hi_nxt = PROD_W'(bound_setting(high_tbl_r, zone_r)) * PROD_W'(coef_r);
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        res_nxt          = '0;
        res_nxt.abnormal = abn;
        if (abn) begin
          if (!entry_r.active) begin
            res_nxt.out_on = 1'b1;
            upd.active     = 1'b1;
            if (mode[1]) begin
              res_nxt.arm_req = !armed_r;
              res_nxt.stop    = 1'b1;
              checked         = 1'b0;
            end else if ((armed_r || mode[0]) && !entry_r.latched) begin
              recent_nxt    = zone_r;
              upd.countdown = {2'b00, delay, 2'b00} + CD_W'(delay);
              upd.latched   = 1'b1;
            end
          end
        end else if (entry_r.active) begin
          upd.active      = 1'b0;
          res_nxt.out_off = 1'b1;
          if (mode[1]) begin
            res_nxt.disarm_req = armed_r;
            res_nxt.stop       = 1'b1;
            checked            = 1'b0;
          end
        end
        if (checked && upd.countdown == '0) begin
          upd.countdown = CD_IDLE;
          res_nxt.fire  = 1'b1;
        end
        ram_we    = 1'b1;
        ram_waddr = zone_r[ZONE_AW-1:0];
        ram_wdata = upd;
        vld_nxt[zone_r[ZONE_AW-1:0]] = 1'b1;
        state_nxt = S_OUT;
      end
      S_SWEEP: begin
        if (op_r == OP_TICK) begin
          if (swp.countdown != CD_IDLE && swp.countdown != '0) begin
            swp.countdown = swp.countdown - CD_W'(1);
          end
        end else begin
          swp.latched = 1'b0;
        end
        ram_we         = 1'b1;
        ram_waddr      = idx_r;
        ram_wdata      = swp;
        vld_nxt[idx_r] = 1'b1;
        if (idx_r == ZONE_AW'(NUM_ZONES - 1)) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + ZONE_AW'(1);
          ram_raddr = idx_r + ZONE_AW'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flags_nxt = res_r;
          out_zone_nxt  = recent_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      recent_r    <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      recent_r    <= recent_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    op_r        <= op_nxt;
    zone_r      <= zone_nxt;
    adc_r       <= adc_nxt;
    pin_r       <= pin_nxt;
    armed_r     <= armed_nxt;
    entry_r     <= entry_nxt;
    prod_lo_r   <= prod_lo_nxt;
    prod_hi_r   <= prod_hi_nxt;
    res_r       <= res_nxt;
    out_flags_r <= out_flags_nxt;
    out_zone_r  <= out_zone_nxt;
    rd_addr_r   <= ram_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r     <= COEF_RST;
      low_tbl_r  <= LOW_TBL_RST;
      high_tbl_r <= HIGH_TBL_RST;
      mode_tbl_r <= MODE_TBL_RST;
      delay_lo_r <= DELAY_LO_RST;
      delay_hi_r <= DELAY_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SUPPLY_COEF: coef_r     <= cfg_data[COEF_W-1:0];
        CFG_LOW_TBL:     low_tbl_r  <= cfg_data[BOUND_TBL_W-1:0];
        CFG_HIGH_TBL:    high_tbl_r <= cfg_data[BOUND_TBL_W-1:0];
        CFG_MODE_TBL:    mode_tbl_r <= cfg_data[MODE_TBL_W-1:0];
        CFG_DELAY_LO:    delay_lo_r <= cfg_data[DELAY_LO_W-1:0];
        CFG_DELAY_HI:    delay_hi_r <= cfg_data[DELAY_HI_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/azm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies; holds the per-zone state of the alarm zone monitor.
`default_nettype none
module azm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[bench/alarm_zone_checker.sv]
// Checker for the alarm zone monitor: watches the request, result and register ports,
// predicts each result from its own copy of the zone state and compares field by field.
// Depends on azm_pkg; instantiated next to the block by alarm_zone_monitor_tb.
module alarm_zone_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [azm_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [azm_pkg::ZONE_W-1:0]     in_zone_index,
  input  wire logic [azm_pkg::ADC_BITS-1:0]   in_adc_sample,
  input  wire logic                           in_pin_level,
  input  wire logic                           in_guard_armed,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           out_zone_abnormal,
  input  wire logic                           out_output_on,
  input  wire logic                           out_output_off,
  input  wire logic                           out_arm_request,
  input  wire logic                           out_disarm_request,
  input  wire logic                           out_alarm_fire,
  input  wire logic                           out_scan_stop,
  input  wire logic [azm_pkg::ZONE_W-1:0]     out_last_alarm_zone,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [azm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [azm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  verdicts_pending
);
  import azm_pkg::*;

  localparam int MODE_24H_BIT    = 0;
  localparam int MODE_BUTTON_BIT = 1;
  localparam int MODE_INVERT_BIT = 2;
  localparam int LOW_DELAY_ZONES = DELAY_LO_W / 8;

  typedef struct packed {
    result_flags_t     flags;
    logic [ZONE_W-1:0] last_zone;
  } zone_verdict_t;

  logic [COEF_W-1:0]      coef;
  logic [BOUND_TBL_W-1:0] low_tbl;
  logic [BOUND_TBL_W-1:0] high_tbl;
  logic [MODE_TBL_W-1:0]  mode_tbl;
  logic [DELAY_LO_W-1:0]  delay_lo_tbl;
  logic [DELAY_HI_W-1:0]  delay_hi_tbl;

  logic              zone_on [NUM_ZONES];
  logic              latched [NUM_ZONES];
  int                countdown [NUM_ZONES];
  logic [ZONE_W-1:0] recent_zone;

  zone_verdict_t pending_verdicts [$];

  function automatic int unsigned window_edge(logic [7:0] setting);
    return 32'(setting) * 32'd300 * 32'(coef) / 32'd100;
  endfunction

  function automatic zone_verdict_t judge_request(opcode_t op, logic [ZONE_W-1:0] zone,
                                                  logic [ADC_BITS-1:0] adc, logic pin,
                                                  logic armed);
    zone_verdict_t v;
    logic [2:0]    mode;
    logic [7:0]    delay;
    logic          abnormal;
    logic          in_window;
    logic          checked;
    int            z;
    v = '0;
    z = int'(zone);
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_ZONES; i++) begin
          if (countdown[i] > 0) countdown[i]--;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_ZONES; i++) latched[i] = 1'b0;
        recent_zone = '0;
      end
      OP_SCAN: begin
        if (z < NUM_ZONES) begin
          mode = mode_tbl[3*z +: 3];
          if (z < NUM_ANALOG_ZONES) begin
            in_window = (window_edge(high_tbl[8*z +: 8]) > adc) &&
                        (window_edge(low_tbl[8*z +: 8]) < adc);
            abnormal = (in_window == mode[MODE_INVERT_BIT]);
          end else begin
            abnormal = (pin == mode[MODE_INVERT_BIT]);
          end
          checked = 1'b1;
          v.flags.abnormal = abnormal;
          if (abnormal) begin
            if (!zone_on[z]) begin
              v.flags.out_on = 1'b1;
              zone_on[z] = 1'b1;
              if (mode[MODE_BUTTON_BIT]) begin
                v.flags.arm_req = !armed;
                v.flags.stop = 1'b1;
                checked = 1'b0;
              end else if ((armed || mode[MODE_24H_BIT]) && !latched[z]) begin
                if (z < LOW_DELAY_ZONES) delay = delay_lo_tbl[8*z +: 8];
                else delay = delay_hi_tbl[8*(z-LOW_DELAY_ZONES) +: 8];
                recent_zone = zone;
                countdown[z] = 5 * int'(delay);
                latched[z] = 1'b1;
              end
            end
          end else if (zone_on[z]) begin
            zone_on[z] = 1'b0;
            v.flags.out_off = 1'b1;
            if (mode[MODE_BUTTON_BIT]) begin
              v.flags.disarm_req = armed;
              v.flags.stop = 1'b1;
              checked = 1'b0;
            end
          end
          if (checked && countdown[z] == 0) begin
            countdown[z] = -1;
            v.flags.fire = 1'b1;
          end
        end
      end
      default: ;
    endcase
    v.last_zone = recent_zone;
    return v;
  endfunction

  function automatic int field_differs(string field, logic [ZONE_W-1:0] want,
                                       logic [ZONE_W-1:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    zone_verdict_t want;
    if (!rst_n) begin
      coef         = COEF_RST;
      low_tbl      = LOW_TBL_RST;
      high_tbl     = HIGH_TBL_RST;
      mode_tbl     = MODE_TBL_RST;
      delay_lo_tbl = DELAY_LO_RST;
      delay_hi_tbl = DELAY_HI_RST;
      for (int i = 0; i < NUM_ZONES; i++) begin
        zone_on[i]   = 1'b0;
        latched[i]   = 1'b0;
        countdown[i] = -1;
      end
      recent_zone = '0;
      pending_verdicts.delete();
      mismatches = 0;
    end else begin
      // Results are retired before new requests are predicted, since a result can never
      // belong to a request accepted at the same edge.
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          mismatches += field_differs("zone_abnormal", ZONE_W'(want.flags.abnormal),
                                      ZONE_W'(out_zone_abnormal));
          mismatches += field_differs("output_on", ZONE_W'(want.flags.out_on),
                                      ZONE_W'(out_output_on));
          mismatches += field_differs("output_off", ZONE_W'(want.flags.out_off),
                                      ZONE_W'(out_output_off));
          mismatches += field_differs("arm_request", ZONE_W'(want.flags.arm_req),
                                      ZONE_W'(out_arm_request));
          mismatches += field_differs("disarm_request", ZONE_W'(want.flags.disarm_req),
                                      ZONE_W'(out_disarm_request));
          mismatches += field_differs("alarm_fire", ZONE_W'(want.flags.fire),
                                      ZONE_W'(out_alarm_fire));
          mismatches += field_differs("scan_stop", ZONE_W'(want.flags.stop),
                                      ZONE_W'(out_scan_stop));
          mismatches += field_differs("last_alarm_zone", want.last_zone, out_last_alarm_zone);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SUPPLY_COEF: coef         = cfg_data[COEF_W-1:0];
          CFG_LOW_TBL:     low_tbl      = cfg_data[BOUND_TBL_W-1:0];
          CFG_HIGH_TBL:    high_tbl     = cfg_data[BOUND_TBL_W-1:0];
          CFG_MODE_TBL:    mode_tbl     = cfg_data[MODE_TBL_W-1:0];
          CFG_DELAY_LO:    delay_lo_tbl = cfg_data[DELAY_LO_W-1:0];
          CFG_DELAY_HI:    delay_hi_tbl = cfg_data[DELAY_HI_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_verdicts.push_back(judge_request(opcode_t'(in_opcode), in_zone_index,
                                                 in_adc_sample, in_pin_level,
                                                 in_guard_armed));
      end
    end
    verdicts_pending = pending_verdicts.size();
  end

endmodule

[bench/alarm_zone_monitor_tb.sv]
// Testbench top for alarm_zone_monitor: clock, reset, register programming, request
// stimulus and result back-pressure. Depends on azm_pkg, alarm_zone_monitor and alarm_zone_checker.
module alarm_zone_monitor_tb;
  import azm_pkg::*;

  localparam int PHASE_REQUESTS = 180;
  localparam int DRAIN_CYCLES   = 16;
  localparam int SET_DIRECTED   = 0;
  localparam int SET_WIDE       = 1;
  localparam int SET_SHUT       = 2;
  localparam int SET_RANDOM     = 3;
  localparam int PHASE_STYLES [6] = '{SET_RANDOM, SET_WIDE, SET_RANDOM, SET_SHUT,
                                      SET_RANDOM, SET_RANDOM};
  localparam int MAX_ZONE_CODE  = (1 << ZONE_W) - 1;
  localparam int MAX_ADC        = (1 << ADC_BITS) - 1;

  // Zone 3 inverted, zone 6 a guard button, zone 7 in 24-hour mode,
  // zone 8 an inverted guard button.
  localparam logic [MODE_TBL_W-1:0] DIRECTED_MODES = 27'h6280800;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   in_opcode = '0;
  logic [ZONE_W-1:0]     in_zone_index = '0;
  logic [ADC_BITS-1:0]   in_adc_sample = '0;
  logic                  in_pin_level = 1'b0;
  logic                  in_guard_armed = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_zone_abnormal;
  logic                  out_output_on;
  logic                  out_output_off;
  logic                  out_arm_request;
  logic                  out_disarm_request;
  logic                  out_alarm_fire;
  logic                  out_scan_stop;
  logic [ZONE_W-1:0]     out_last_alarm_zone;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    verdicts_pending;

  logic [COEF_W-1:0]      coef_now = COEF_RST;
  logic [BOUND_TBL_W-1:0] low_now = LOW_TBL_RST;
  logic [BOUND_TBL_W-1:0] high_now = HIGH_TBL_RST;
  logic                   armed_now = 1'b1;
  int                     burst_left = 0;

  int          stall_left = 0;
  int          stall_style = 0;
  int unsigned stall_tick = 0;

  always #6 clk = ~clk;

  alarm_zone_monitor dut (.*);

  alarm_zone_checker chk (.*);

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (stall_tick % 5 < 2);
      default: out_ready <= (stall_tick % 11 == 0);
    endcase
  end

  task automatic issue(opcode_t op, logic [ZONE_W-1:0] zone, logic [ADC_BITS-1:0] adc,
                       logic pin, logic armed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_zone_index  <= zone;
    in_adc_sample  <= adc;
    in_pin_level   <= pin;
    in_guard_armed <= armed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(int style);
    logic [CFG_DATA_W-1:0] coef_word;
    logic [CFG_DATA_W-1:0] low_word;
    logic [CFG_DATA_W-1:0] high_word;
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] dly_lo_word;
    logic [CFG_DATA_W-1:0] dly_hi_word;
    // Unused upper data bits stay random so that the register widths are exercised.
    coef_word   = CFG_DATA_W'({$urandom(), $urandom()});
    low_word    = CFG_DATA_W'({$urandom(), $urandom()});
    high_word   = CFG_DATA_W'({$urandom(), $urandom()});
    mode_word   = CFG_DATA_W'({$urandom(), $urandom()});
    dly_lo_word = CFG_DATA_W'({$urandom(), $urandom()});
    dly_hi_word = CFG_DATA_W'({$urandom(), $urandom()});
    case (style)
      SET_DIRECTED: begin
        coef_word[COEF_W-1:0]       = COEF_RST;
        low_word                    = 40'h0A0A0A0A0A;
        high_word                   = 40'h6464646464;
        mode_word[MODE_TBL_W-1:0]   = DIRECTED_MODES;
        dly_lo_word                 = 40'h0000000001;
        dly_hi_word[DELAY_HI_W-1:0] = 32'h00000002;
      end
      SET_WIDE: begin
        coef_word[COEF_W-1:0]       = '1;
        low_word                    = '0;
        high_word                   = '1;
        mode_word[MODE_TBL_W-1:0]   = '1;
        dly_lo_word                 = '1;
        dly_hi_word[DELAY_HI_W-1:0] = '1;
      end
      SET_SHUT: begin
        coef_word[COEF_W-1:0]       = '0;
        low_word                    = '1;
        high_word                   = '0;
        mode_word[MODE_TBL_W-1:0]   = '0;
        dly_lo_word                 = '0;
        dly_hi_word[DELAY_HI_W-1:0] = '0;
      end
      default: begin
        // Short delays let the countdowns reach zero within a phase.
        dly_lo_word              = dly_lo_word & 40'h0303030303;
        dly_hi_word[DELAY_HI_W-1:0] = dly_hi_word[DELAY_HI_W-1:0] & 32'h03030303;
      end
    endcase
    write_reg(CFG_SUPPLY_COEF, coef_word);
    write_reg(CFG_LOW_TBL, low_word);
    write_reg(CFG_HIGH_TBL, high_word);
    write_reg(CFG_MODE_TBL, mode_word);
    write_reg(CFG_DELAY_LO, dly_lo_word);
    write_reg(CFG_DELAY_HI, dly_hi_word);
    coef_now = coef_word[COEF_W-1:0];
    low_now  = low_word[BOUND_TBL_W-1:0];
    high_now = high_word[BOUND_TBL_W-1:0];
  endtask

  // Most analog samples land within a few counts of a window bound.
  function automatic logic [ADC_BITS-1:0] pick_adc(int z);
    int          pick;
    int unsigned boundary;
    int          shifted;
    pick = $urandom_range(0, 9);
    if (z >= NUM_ANALOG_ZONES || pick == 9) return ADC_BITS'($urandom_range(0, MAX_ADC));
    if (pick == 7) return '0;
    if (pick == 8) return '1;
    boundary = 32'((pick < 5) ? low_now[8*z +: 8] : high_now[8*z +: 8]) * 32'd300 *
               32'(coef_now) / 32'd100;
    if (boundary > MAX_ADC + 2) return ADC_BITS'($urandom_range(0, MAX_ADC));
    shifted = int'(boundary) + int'($urandom_range(0, 4)) - 2;
    if (shifted < 0) shifted = 0;
    if (shifted > MAX_ADC) shifted = MAX_ADC;
    return shifted[ADC_BITS-1:0];
  endfunction

  task automatic random_phase(int count);
    int r;
    int z;
    repeat (count) begin
      if ($urandom_range(0, 11) == 0) armed_now = !armed_now;
      r = $urandom_range(0, 99);
      z = $urandom_range(0, NUM_ZONES - 1);
      if (r < 62) begin
        issue(OP_SCAN, ZONE_W'(z), pick_adc(z), 1'($urandom_range(0, 1)), armed_now);
      end else if (r < 82) begin
        issue(OP_TICK, ZONE_W'($urandom_range(0, MAX_ZONE_CODE)),
              ADC_BITS'($urandom_range(0, MAX_ADC)), 1'($urandom_range(0, 1)), armed_now);
      end else if (r < 90) begin
        issue(OP_CLEAR, ZONE_W'($urandom_range(0, MAX_ZONE_CODE)),
              ADC_BITS'($urandom_range(0, MAX_ADC)), 1'($urandom_range(0, 1)), armed_now);
      end else if (r < 94) begin
        issue(OP_NOP, ZONE_W'($urandom_range(0, MAX_ZONE_CODE)),
              ADC_BITS'($urandom_range(0, MAX_ADC)), 1'($urandom_range(0, 1)), armed_now);
      end else begin
        issue(OP_SCAN, ZONE_W'($urandom_range(NUM_ZONES, MAX_ZONE_CODE)),
              ADC_BITS'($urandom_range(0, MAX_ADC)), 1'($urandom_range(0, 1)), armed_now);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zone 0 has a delay, the other zones fire on the latching scan.
    issue(OP_SCAN, 4'd0, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd0, 12'd4095, 1'b1, 1'b1);
    issue(OP_SCAN, 4'd5, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd5, 12'd4095, 1'b1, 1'b1);
    issue(OP_TICK, 4'd15, 12'd4095, 1'b1, 1'b1);
    issue(OP_CLEAR, 4'd8, 12'd0, 1'b0, 1'b0);
    issue(OP_NOP, 4'd3, 12'd100, 1'b1, 1'b0);
    issue(OP_SCAN, 4'd9, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd15, 12'd4095, 1'b1, 1'b1);
    issue(OP_SCAN, 4'd4, 12'd2048, 1'b0, 1'b0);

    settle();
    program_settings(SET_DIRECTED);
    issue(OP_SCAN, 4'd6, 12'd0, 1'b0, 1'b0);
    issue(OP_SCAN, 4'd6, 12'd0, 1'b1, 1'b1);
    issue(OP_SCAN, 4'd6, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd6, 12'd0, 1'b1, 1'b0);
    issue(OP_SCAN, 4'd7, 12'd0, 1'b0, 1'b0);
    issue(OP_SCAN, 4'd3, 12'd100, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd0, 12'd0, 1'b0, 1'b1);
    repeat (5) issue(OP_TICK, 4'd0, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd0, 12'd0, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd0, 12'd30, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd0, 12'd31, 1'b0, 1'b1);
    issue(OP_SCAN, 4'd8, 12'd0, 1'b1, 1'b0);
    issue(OP_CLEAR, 4'd0, 12'd0, 1'b0, 1'b1);

    foreach (PHASE_STYLES[p]) begin
      settle();
      program_settings(PHASE_STYLES[p]);
      random_phase(PHASE_REQUESTS);
    end

    settle();
    @(negedge clk);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("alarm_zone_monitor_tb: done, clean");
    end else begin
      $display("alarm_zone_monitor_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("alarm_zone_monitor_tb: done, errors");
    $finish;
  end

endmodule

[filelist.f]
hdl/azm_pkg.sv
hdl/azm_ram.sv
hdl/alarm_zone_monitor.sv
bench/alarm_zone_checker.sv
bench/alarm_zone_monitor_tb.sv
